@@ hw/rtl/ebb_pkg.sv @@
// ----------------------------------------------------------------------------
// ebb_pkg
// Shared types, constants and the micro-op table of the bouncing-body
// Euler step unit.
// ----------------------------------------------------------------------------
package ebb_pkg;

	// Micro-op sequence
	localparam int              NUM_OPS        = 11;
	localparam int              OP_IDX_W       = 4;
	localparam logic [3:0]      OP_LAST        = 4'(NUM_OPS - 1);
	localparam logic [3:0]      OP_FLOOR_FIRST = 4'd6;

	// Q16.16 constants
	localparam logic signed [31:0] Q_HALF  = 32'sd32768;
	localparam logic signed [31:0] Q_TENTH = 32'sd6554;
	localparam logic signed [31:0] Q_TEN   = 32'sd655360;
	// Q0.16 multiplier constants
	localparam logic [16:0]        Q_FRIC     = 17'd58982;
	localparam logic [16:0]        Q_HALF_MUL = 17'd32768;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_ACCEL_X        = 3'd0,
		CFG_ACCEL_Y        = 3'd1,
		CFG_ACCEL_Z        = 3'd2,
		CFG_GRAVITY_ON     = 3'd3,
		CFG_BOUNCE_DAMPING = 3'd4
	} cfg_idx_t;

	// Multiplier operand A source
	typedef enum logic [1:0] {
		A_ACC    = 2'd0,
		A_VEL    = 2'd1,
		A_NEGVEL = 2'd2
	} a_sel_t;

	// Multiplier operand B source
	typedef enum logic [1:0] {
		B_DT   = 2'd0,
		B_DAMP = 2'd1,
		B_FRIC = 2'd2,
		B_HALF = 2'd3
	} b_sel_t;

	// Condition under which a micro-op runs
	typedef enum logic [2:0] {
		C_ALWAYS    = 3'd0,
		C_GRAV      = 3'd1,
		C_FLOOR_NOW = 3'd2,
		C_FLOOR     = 3'd3,
		C_BND_X     = 3'd4,
		C_BND_Z     = 3'd5
	} cond_t;

	typedef struct packed {
		a_sel_t      a_sel;
		b_sel_t      b_sel;
		logic [1:0]  axis;
		logic        to_pos;     // write the position, else the velocity
		logic        accum;      // add the product to the destination
		logic        zero_small; // zero a result under one tenth
		logic        floor_pos;  // force height to one half
		logic        clamp_pos;  // clamp the position to the bounds
		cond_t       cond;
	} op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic                 load_in;
		logic                 issue;
		logic                 wb;
		logic                 out_load;
		logic [OP_IDX_W-1:0]  op_idx;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic grav_on;
		logic floor_now;
		logic bnd_x;
		logic bnd_z;
	} status_t;

	// Micro-op table: gravity, position update, floor bounce, side walls
	function automatic op_t op_info(input logic [3:0] idx);
		op_t o;
		o = '{a_sel: A_VEL, b_sel: B_DT, axis: 2'd0, to_pos: 1'b0, accum: 1'b0,
			zero_small: 1'b0, floor_pos: 1'b0, clamp_pos: 1'b0, cond: C_ALWAYS};
		case (idx)
			4'd0: begin o.a_sel = A_ACC; o.axis = 2'd0; o.accum = 1'b1; o.cond = C_GRAV; end
			4'd1: begin o.a_sel = A_ACC; o.axis = 2'd1; o.accum = 1'b1; o.cond = C_GRAV; end
			4'd2: begin o.a_sel = A_ACC; o.axis = 2'd2; o.accum = 1'b1; o.cond = C_GRAV; end
			4'd3: begin o.axis = 2'd0; o.to_pos = 1'b1; o.accum = 1'b1; end
			4'd4: begin o.axis = 2'd1; o.to_pos = 1'b1; o.accum = 1'b1; end
			4'd5: begin o.axis = 2'd2; o.to_pos = 1'b1; o.accum = 1'b1; end
			4'd6: begin
				o.a_sel = A_NEGVEL; o.b_sel = B_DAMP; o.axis = 2'd1;
				o.zero_small = 1'b1; o.floor_pos = 1'b1; o.cond = C_FLOOR_NOW;
			end
			4'd7: begin o.b_sel = B_FRIC; o.axis = 2'd0; o.cond = C_FLOOR; end
			4'd8: begin o.b_sel = B_FRIC; o.axis = 2'd2; o.cond = C_FLOOR; end
			4'd9: begin
				o.a_sel = A_NEGVEL; o.b_sel = B_HALF; o.axis = 2'd0;
				o.clamp_pos = 1'b1; o.cond = C_BND_X;
			end
			4'd10: begin
				o.a_sel = A_NEGVEL; o.b_sel = B_HALF; o.axis = 2'd2;
				o.clamp_pos = 1'b1; o.cond = C_BND_Z;
			end
			default: o.cond = C_ALWAYS;
		endcase
		return o;
	endfunction

endpackage

@@ hw/rtl/ebb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ebb_ctrl
// Sequencer of the step unit: accepts a request, walks the micro-op table
// one multiply at a time and hands the result to the output register.
// ----------------------------------------------------------------------------
module ebb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  ebb_pkg::status_t st,
	output ebb_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_ISSUE  = 4'b0010,
		S_WB     = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t      state_q;
	logic [3:0]  idx_q;
	logic        floor_q;
	logic        m_valid_q;
	logic        op_en;
	logic        slot_free;
	ebb_pkg::op_t op;

	assign op        = ebb_pkg::op_info(idx_q);
	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_valid_q;

	// Decide whether the current micro-op runs
	always_comb begin
		case (op.cond)
			ebb_pkg::C_ALWAYS:    op_en = 1'b1;
			ebb_pkg::C_GRAV:      op_en = st.grav_on;
			ebb_pkg::C_FLOOR_NOW: op_en = st.floor_now;
			ebb_pkg::C_FLOOR:     op_en = floor_q;
			ebb_pkg::C_BND_X:     op_en = st.bnd_x;
			ebb_pkg::C_BND_Z:     op_en = st.bnd_z;
			default:              op_en = 1'b0;
		endcase
	end

	// Drive commands from the state
	always_comb begin
		cmd.load_in  = (state_q == S_IDLE) && s_tvalid;
		cmd.issue    = (state_q == S_ISSUE) && op_en;
		cmd.wb       = (state_q == S_WB);
		cmd.out_load = (state_q == S_FINISH) && slot_free;
		cmd.op_idx   = idx_q;
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			floor_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// hold the result until the consumer takes it
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						idx_q   <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					// hold the floor hit seen before the bounce changes it
					if (idx_q == ebb_pkg::OP_FLOOR_FIRST) begin
						floor_q <= st.floor_now;
					end
					if (op_en) begin
						state_q <= S_WB;
					end else if (idx_q == ebb_pkg::OP_LAST) begin
						state_q <= S_FINISH;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_WB: begin
					if (idx_q == ebb_pkg::OP_LAST) begin
						state_q <= S_FINISH;
					end else begin
						idx_q   <= idx_q + 4'd1;
						state_q <= S_ISSUE;
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_ISSUE && idx_q == 4'd0)
		else $error("accepted request did not start the sequence");

	a_wb_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> $past(cmd.issue))
		else $error("writeback without a multiply issued");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !m_valid_q || m_tready)
		else $error("output register overwritten before it was taken");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= ebb_pkg::OP_LAST)
		else $error("micro-op index beyond the table");

endmodule

@@ hw/rtl/ebb_dpath.sv @@
// ----------------------------------------------------------------------------
// ebb_dpath
// Datapath of the step unit: configuration registers, velocity state,
// working position, one shared Q16.16 multiplier and the output register.
// ----------------------------------------------------------------------------
module ebb_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_wdata,
	input  logic [111:0]     s_tdata,
	output logic [191:0]     m_tdata,
	input  ebb_pkg::cmd_t    cmd,
	output ebb_pkg::status_t st
);

	logic signed [31:0] accel_x_q, accel_y_q, accel_z_q;
	logic               gravity_on_q;
	logic [16:0]        damping_q;
	logic [15:0]        dt_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [50:0] prod_q;
	logic [191:0]       out_q;

	ebb_pkg::op_t       op;
	logic signed [31:0] acc_sel, vel_sel, pos_sel, dst_sel;
	logic signed [32:0] a_op;
	logic [16:0]        b_op;
	logic signed [51:0] rnd;
	logic signed [35:0] shr;
	logic signed [31:0] mres;
	logic signed [32:0] sum;
	logic signed [31:0] res;
	logic signed [31:0] clamp_val;

	function automatic logic signed [31:0] sat36(input logic signed [35:0] x);
		if (x > 36'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (x < -36'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
		if (x[32] != x[31]) begin
			return x[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end
		return x[31:0];
	endfunction

	assign op = ebb_pkg::op_info(cmd.op_idx);

	// Select the axis operands
	always_comb begin
		case (op.axis)
			2'd0: begin acc_sel = accel_x_q; vel_sel = vel_q[0]; pos_sel = pos_q[0]; end
			2'd1: begin acc_sel = accel_y_q; vel_sel = vel_q[1]; pos_sel = pos_q[1]; end
			default: begin acc_sel = accel_z_q; vel_sel = vel_q[2]; pos_sel = pos_q[2]; end
		endcase
	end

	// Select the multiplier operands
	always_comb begin
		case (op.a_sel)
			ebb_pkg::A_ACC:    a_op = {acc_sel[31], acc_sel};
			ebb_pkg::A_VEL:    a_op = {vel_sel[31], vel_sel};
			ebb_pkg::A_NEGVEL: a_op = -{vel_sel[31], vel_sel};
			default:           a_op = {vel_sel[31], vel_sel};
		endcase
		case (op.b_sel)
			ebb_pkg::B_DT:   b_op = {1'b0, dt_q};
			ebb_pkg::B_DAMP: b_op = damping_q;
			ebb_pkg::B_FRIC: b_op = ebb_pkg::Q_FRIC;
			default:         b_op = ebb_pkg::Q_HALF_MUL;
		endcase
	end

	// Round half up, saturate, accumulate into the destination where the micro-op asks, zero small results, clamp
	always_comb begin
		rnd     = {prod_q[50], prod_q} + 52'sd32768;
		shr     = rnd[51:16];
		mres    = sat36(shr);
		dst_sel = op.to_pos ? pos_sel : vel_sel;
		sum     = {dst_sel[31], dst_sel} + {mres[31], mres};
		res     = op.accum ? sat33(sum) : mres;
		if (op.zero_small && res < ebb_pkg::Q_TENTH && res > -ebb_pkg::Q_TENTH) begin
			res = '0;
		end
		if (pos_sel > ebb_pkg::Q_TEN) begin
			clamp_val = ebb_pkg::Q_TEN;
		end else if (pos_sel < -ebb_pkg::Q_TEN) begin
			clamp_val = -ebb_pkg::Q_TEN;
		end else begin
			clamp_val = pos_sel;
		end
	end

	// Report conditions to the sequencer
	always_comb begin
		st.grav_on   = gravity_on_q;
		st.floor_now = (pos_q[1] < ebb_pkg::Q_HALF) && vel_q[1][31];
		st.bnd_x     = (pos_q[0] > ebb_pkg::Q_TEN) || (pos_q[0] < -ebb_pkg::Q_TEN);
		st.bnd_z     = (pos_q[2] > ebb_pkg::Q_TEN) || (pos_q[2] < -ebb_pkg::Q_TEN);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_x_q    <= 32'sd0;
			accel_y_q    <= -32'sd642908;
			accel_z_q    <= 32'sd0;
			gravity_on_q <= 1'b1;
			damping_q    <= 17'd45875;
		end else if (cfg_we) begin
			case (cfg_index)
				ebb_pkg::CFG_ACCEL_X:        accel_x_q    <= cfg_wdata;
				ebb_pkg::CFG_ACCEL_Y:        accel_y_q    <= cfg_wdata;
				ebb_pkg::CFG_ACCEL_Z:        accel_z_q    <= cfg_wdata;
				ebb_pkg::CFG_GRAVITY_ON:     gravity_on_q <= cfg_wdata[0];
				ebb_pkg::CFG_BOUNCE_DAMPING: damping_q    <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// Velocity state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				vel_q[k] <= '0;
			end
		end else if (cmd.wb && !op.to_pos) begin
			for (int k = 0; k < 3; k++) begin
				if (op.axis == 2'(k)) begin
					vel_q[k] <= res;
				end
			end
		end
	end

	// Working position, time step, product and output register
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			dt_q     <= s_tdata[15:0];
			pos_q[0] <= s_tdata[47:16];
			pos_q[1] <= s_tdata[79:48];
			pos_q[2] <= s_tdata[111:80];
		end else if (cmd.wb) begin
			for (int k = 0; k < 3; k++) begin
				if (op.axis == 2'(k)) begin
					if (op.to_pos) begin
						pos_q[k] <= res;
					end else if (op.clamp_pos) begin
						pos_q[k] <= clamp_val;
					end
				end
			end
			if (op.floor_pos) begin
				pos_q[1] <= ebb_pkg::Q_HALF;
			end
		end
		if (cmd.issue) begin
			prod_q <= a_op * $signed({1'b0, b_op});
		end
		if (cmd.out_load) begin
			out_q <= {vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
		end
	end

	assign m_tdata = out_q;

endmodule

@@ hw/rtl/euler_bounce_body_step_unit.sv @@
// ----------------------------------------------------------------------------
// euler_bounce_body_step_unit
// Semi-implicit Euler step of one bouncing body in saturating Q16.16.
// ----------------------------------------------------------------------------
// Each request carries a time step and the body's position; the unit keeps
// the velocity, applies gravity, moves the body, bounces it off the floor at
// height 0.5 and off the side walls at +-10, and returns the new position
// and velocity. After a request is accepted, the sequencer checks each of the
// eleven micro-ops in turn and writes back each one that runs (three gravity,
// three position, up to three floor and two wall updates), then loads the
// output register; the load waits as long as the previous result still sits
// in the output register. A new request is taken only once the unit is idle
// again, after the previous result has been loaded. The single shared 33x18
// multiplier serves every micro-op, each product registered and written back
// in the next cycle. A finished result waits in the output register while the
// next request is taken. Configuration must be written only while the unit
// is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module euler_bounce_body_step_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// delta_t[15:0], pos_x[47:16], pos_y[79:48], pos_z[111:80]
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_pos_x[31:0], new_pos_y[63:32], new_pos_z[95:64],
	// out_vel_x[127:96], out_vel_y[159:128], out_vel_z[191:160]
	output logic [191:0] m_tdata
);

	ebb_pkg::cmd_t    cmd;
	ebb_pkg::status_t st;

	ebb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ebb_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
